/* design/vpp_pkg.sv */
// Package: widths, reset values and register indexes of the valve pulse positioner.
package vpp_pkg;

  localparam int TIME_BITS_DEF = 20;
  localparam int TEMP_BITS_DEF = 13;

  localparam int CFG_W   = 20;  // widest register
  localparam int ERR_W   = 12;  // deadband and max_error registers
  localparam int INDEX_W = 3;

  localparam logic [CFG_W-1:0] ADJUST_INTERVAL_RST = 20'd10000;
  localparam logic [ERR_W-1:0] DEADBAND_RST        = 12'd16;
  localparam logic [ERR_W-1:0] MAX_ERROR_RST       = 12'd160;
  localparam logic [CFG_W-1:0] MIN_PULSE_RST       = 20'd500;
  localparam logic [CFG_W-1:0] MAX_PULSE_RST       = 20'd5000;

  typedef enum logic [INDEX_W-1:0] {
    REG_ADJUST_INTERVAL = 3'd0,
    REG_DEADBAND        = 3'd1,
    REG_MAX_ERROR       = 3'd2,
    REG_MIN_PULSE       = 3'd3,
    REG_MAX_PULSE       = 3'd4
  } reg_index_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_LEN  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

/* design/valve_pulse_positioner_top.sv */
// Valve pulse positioner: times open/close pulses for a three-point mixing valve.
//
// Usage: one input request per millisecond tick on in_valid/in_ready carries
// target_temp, actual_temp (signed, 1/16 degree) and actual_valid. Each request
// yields exactly one result on out_valid/out_ready: the relay levels open_drive,
// close_drive and pulse_active after that tick's update.
// Config: cfg_write with cfg_index/cfg_data writes one register; the user must write
// only while no request is in flight, as the block itself does not enforce this.
// Steps: a tick that times a running pulse, skips or has no adjustment due goes
// through evaluate and output; one that hits the full span through evaluate,
// length and output. A tick that needs a proportional share runs a bit-serial
// shift-add multiply and a restoring divide, one bit per cycle, before length.
// Requests: one at a time, a new one is taken only back in idle; in_ready is high in
// idle. The output register frees the input side, so the next request is taken
// while a result still waits; it then holds in its final cycle until the receiver
// takes the earlier result. A stalled receiver never loses or repeats a result.
// Reset (rst, synchronous): registers return to their defaults, no pulse runs,
// relays off, counters zero, no result pending.
module valve_pulse_positioner_top #(
  parameter int TIME_BITS = vpp_pkg::TIME_BITS_DEF,
  parameter int TEMP_BITS = vpp_pkg::TEMP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [vpp_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [vpp_pkg::CFG_W-1:0]      cfg_data,
  // tick requests
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [TEMP_BITS-1:0]    target_temp,
  input  logic signed [TEMP_BITS-1:0]    actual_temp,
  input  logic                           actual_valid,
  // results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           open_drive,
  output logic                           close_drive,
  output logic                           pulse_active
);
  import vpp_pkg::*;

  localparam int MAG_W  = TEMP_BITS + 1;
  localparam int CMP_W  = (MAG_W > ERR_W) ? MAG_W : ERR_W;
  localparam int PROD_W = TIME_BITS + ERR_W;
  localparam int CNT_W  = $clog2(PROD_W + 1);

  // configuration registers
  logic [TIME_BITS-1:0] adjust_interval;
  logic [ERR_W-1:0]     deadband;
  logic [ERR_W-1:0]     max_error;
  logic [TIME_BITS-1:0] min_pulse;
  logic [TIME_BITS-1:0] max_pulse;

  // controller state
  logic [TIME_BITS-1:0] pulse_length;
  logic [TIME_BITS-1:0] pulse_elapsed;
  logic [TIME_BITS-1:0] adjust_elapsed;
  logic                 open_level;
  logic                 close_level;

  // request capture and datapath
  state_t                     state;
  logic signed [TEMP_BITS-1:0] tgt;
  logic signed [TEMP_BITS-1:0] act;
  logic                       vld;
  logic                       dir_open;
  logic [TIME_BITS-1:0]       span;
  logic [TIME_BITS-1:0]       share;
  logic [ERR_W-1:0]           mq;     // multiplier bits, MSB first
  logic [PROD_W-1:0]          prod;   // product, then dividend/quotient
  logic [ERR_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;

  // evaluate-cycle logic
  logic signed [MAG_W-1:0] err;
  logic [MAG_W-1:0]        mag;
  logic [CMP_W-1:0]        mag_x;
  logic [TIME_BITS-1:0]    adj_inc;
  logic [TIME_BITS-1:0]    pe_inc;
  logic [TIME_BITS-1:0]    span_now;
  logic                    skip;
  logic                    full_span;

  // serial steps
  logic [PROD_W-1:0]       mul_next;
  logic [ERR_W:0]          div_try;
  logic                    div_ge;
  logic [ERR_W:0]          div_sub;
  logic [TIME_BITS:0]      len_sum;
  logic [TIME_BITS-1:0]    len;

  always_comb begin
    err       = MAG_W'(tgt) - MAG_W'(act);
    mag       = err[MAG_W-1] ? MAG_W'(-err) : MAG_W'(err);
    mag_x     = CMP_W'(mag);
    adj_inc   = (&adjust_elapsed) ? adjust_elapsed : adjust_elapsed + 1'b1;
    pe_inc    = (&pulse_elapsed) ? pulse_elapsed : pulse_elapsed + 1'b1;
    span_now  = (max_pulse > min_pulse) ? max_pulse - min_pulse : '0;
    skip      = tgt[TEMP_BITS-1] || !vld || (mag_x <= CMP_W'(deadband));
    full_span = (max_error == '0) || (mag_x >= CMP_W'(max_error));

    // shift-add, one multiplier bit per cycle
    mul_next  = {prod[PROD_W-2:0], 1'b0} + (mq[ERR_W-1] ? PROD_W'(span) : '0);

    // restoring divide, one quotient bit per cycle
    div_try   = {rem, prod[PROD_W-1]};
    div_ge    = div_try >= {1'b0, max_error};
    div_sub   = div_try - {1'b0, max_error};

    len_sum   = {1'b0, min_pulse} + {1'b0, share};
    len       = len_sum[TIME_BITS-1:0];
  end

  assign in_ready = (state == ST_IDLE);

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_interval <= TIME_BITS'(ADJUST_INTERVAL_RST);
      deadband        <= DEADBAND_RST;
      max_error       <= MAX_ERROR_RST;
      min_pulse       <= TIME_BITS'(MIN_PULSE_RST);
      max_pulse       <= TIME_BITS'(MAX_PULSE_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ADJUST_INTERVAL: adjust_interval <= TIME_BITS'(cfg_data);
        REG_DEADBAND:        deadband        <= cfg_data[ERR_W-1:0];
        REG_MAX_ERROR:       max_error       <= cfg_data[ERR_W-1:0];
        REG_MIN_PULSE:       min_pulse       <= TIME_BITS'(cfg_data);
        REG_MAX_PULSE:       max_pulse       <= TIME_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          tgt <= target_temp;
          act <= actual_temp;
          vld <= actual_valid;
        end
      end
      ST_EVAL: begin
        dir_open <= !err[MAG_W-1] && (err != '0);
        span     <= span_now;
        share    <= span_now;
        mq       <= ERR_W'(mag);
        prod     <= '0;
        rem      <= '0;
      end
      ST_MUL: begin
        prod <= mul_next;
        mq   <= {mq[ERR_W-2:0], 1'b0};
      end
      ST_DIV: begin
        rem  <= div_ge ? div_sub[ERR_W-1:0] : div_try[ERR_W-1:0];
        prod <= {prod[PROD_W-2:0], div_ge};
        if (cnt == CNT_W'(1)) begin
          share <= TIME_BITS'({prod[PROD_W-2:0], div_ge});
        end
      end
      default: ;
    endcase
  end

  // sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cnt            <= '0;
      pulse_length   <= '0;
      pulse_elapsed  <= '0;
      adjust_elapsed <= '0;
      open_level     <= 1'b0;
      close_level    <= 1'b0;
      out_valid      <= 1'b0;
      open_drive     <= 1'b0;
      close_drive    <= 1'b0;
      pulse_active   <= 1'b0;
    end else begin
      // in ST_FIN the load below covers a taken result
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (pulse_length != '0) begin
            state          <= ST_FIN;
            adjust_elapsed <= adj_inc;
            pulse_elapsed  <= pe_inc;
            if (pe_inc >= pulse_length) begin
              pulse_length <= '0;
              open_level   <= 1'b0;
              close_level  <= 1'b0;
            end
          end else if (adj_inc >= adjust_interval) begin
            adjust_elapsed <= '0;
            if (skip) begin
              state <= ST_FIN;
            end else if (full_span) begin
              state <= ST_LEN;
            end else begin
              state <= ST_MUL;
              cnt   <= CNT_W'(ERR_W);
            end
          end else begin
            state          <= ST_FIN;
            adjust_elapsed <= adj_inc;
          end
        end
        ST_MUL: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_DIV;
            cnt   <= CNT_W'(PROD_W);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          state <= ST_FIN;
          if (len == '0) begin
            open_level  <= 1'b0;
            close_level <= 1'b0;
          end else begin
            pulse_length  <= len;
            pulse_elapsed <= '0;
            open_level    <= dir_open;
            close_level   <= !dir_open;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            open_drive   <= open_level;
            close_drive  <= close_level;
            pulse_active <= (pulse_length != '0);
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
